@@ hw/rtl/pulse_rate_meter_macros.svh @@
// Assertion macros shared by the pulse rate meter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PULSE_RATE_METER_MACROS_SVH
`define PULSE_RATE_METER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/prm_pkg.sv @@
// Package for the pulse rate meter: widths, constants, item and job types.
// Depends on nothing; used by every module of the block.
package prm_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 16;
    localparam int THR_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_CNT_W   = $clog2(RATE_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_AW + 1;

    localparam logic [RATE_W-1:0] RATE_NUM = 16'd60000;
    localparam logic [RATE_W-1:0] RATE_MAX = 16'd60000;
    localparam logic [THR_W-1:0]  UPPER_RESET = 10'd512;
    localparam logic [THR_W-1:0]  LOWER_RESET = 10'd100;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_ms;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0] rate_bpm;
        logic              beat;
    } t_out;

    // What the back end has to do with one item.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SAT,
        OP_ZERO,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [RATE_W-1:0] divisor;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ hw/rtl/prm_fifo.sv @@
// Short job queue between the front and back ends of the pulse rate meter.
// Depends on prm_pkg.
module prm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  prm_pkg::t_job     i_job,
    input  logic              i_pop,
    output prm_pkg::t_job     o_head,
    output prm_pkg::t_q_status o_status
);
    import prm_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   push_ok;
    logic                   pop_ok;

    assign o_status.full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/prm_front.sv @@
// Front end of the pulse rate meter: threshold registers, hysteresis state
// and classification of each item into a job. Depends on prm_pkg and the macros.
`include "pulse_rate_meter_macros.svh"

module prm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prm_pkg::THR_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  prm_pkg::t_in                    i_in,
    input  prm_pkg::t_q_status              i_q_status,
    output logic                            o_push,
    output prm_pkg::t_job                   o_job
);
    import prm_pkg::*;

    logic [THR_W-1:0]  r_upper;
    logic [THR_W-1:0]  r_lower;
    logic [TIME_W-1:0] r_start;
    logic              r_timing;
    logic              r_armed;

    logic              above;
    logic              below;
    logic              beat_now;
    logic [TIME_W-1:0] interval;
    logic              n_timing;
    logic              n_armed;
    logic              restart;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_status.full;
    assign o_push      = i_in_valid && !i_q_status.full;

    assign above    = i_in.sample > r_upper;
    assign below    = i_in.sample < r_lower;
    assign beat_now = above && r_armed;
    assign interval = i_in.time_ms - r_start;

    // Upper test first, then the lower test sees the updated timing flag.
    always_comb begin
        n_timing = beat_now ? 1'b0 : r_timing;
        n_armed  = beat_now ? 1'b0 : r_armed;
        restart  = above && !n_timing;
        if (restart) begin
            n_timing = 1'b1;
        end
        if (below && n_timing) begin
            n_armed = 1'b1;
        end
    end

    always_comb begin
        o_job.divisor = interval[RATE_W-1:0];
        if (!beat_now) begin
            o_job.op = OP_HOLD;
        end else if (interval == '0) begin
            o_job.op = OP_SAT;
        end else if (interval > {{(TIME_W-RATE_W){1'b0}}, RATE_NUM}) begin
            o_job.op = OP_ZERO;
        end else begin
            o_job.op = OP_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper  <= UPPER_RESET;
            r_lower  <= LOWER_RESET;
            r_start  <= '0;
            r_timing <= 1'b0;
            r_armed  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_UPPER: begin
                        r_upper <= i_cfg_data;
                    end
                    REG_LOWER: begin
                        r_lower <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                r_timing <= n_timing;
                r_armed  <= n_armed;
                if (restart) begin
                    r_start <= i_in.time_ms;
                end
            end
        end
    end

    `PRM_ASSERT_NOW(a_armed_needs_timing, i_clk, i_rst_n, r_armed, r_timing,
        "beat armed without timing active")
    `PRM_ASSERT_NOW(a_low_sample_holds, i_clk, i_rst_n,
        o_push && (i_in.sample <= r_upper), o_job.op == OP_HOLD,
        "beat counted on a sample not above the upper threshold")
    `PRM_ASSERT_NEXT(a_beat_restarts, i_clk, i_rst_n, o_push && (o_job.op != OP_HOLD),
        r_timing && (r_start == $past(i_in.time_ms)),
        "beat did not restart timing at the item's time")

endmodule

@@ hw/rtl/prm_back.sv @@
// Back end of the pulse rate meter: held rate, bit-serial divider and the
// output register. Depends on prm_pkg and the macros.
`include "pulse_rate_meter_macros.svh"

module prm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prm_pkg::t_job      i_head,
    input  prm_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output prm_pkg::t_out      o_out
);
    import prm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [RATE_W-1:0]    r_held;
    logic [RATE_W-1:0]    r_div;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    t_out                 r_out;

    t_state               n_state;
    logic [RATE_W-1:0]    n_held;
    logic [RATE_W-1:0]    n_div;
    logic [RATE_W-1:0]    n_rem;
    logic [RATE_W-1:0]    n_quo;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 n_out_valid;
    t_out                 n_out;

    logic                 out_free;
    logic [RATE_W:0]      rem_sh;
    logic                 fits;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_q_status.empty && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // One restoring step: bring down the next numerator bit, try the subtract.
    assign rem_sh = {r_rem, RATE_NUM[r_cnt]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (i_head.op)
                        OP_HOLD: begin
                            n_out_valid   = 1'b1;
                            n_out.rate_bpm = r_held;
                            n_out.beat    = 1'b0;
                        end
                        OP_SAT: begin
                            n_held        = RATE_MAX;
                            n_out_valid   = 1'b1;
                            n_out.rate_bpm = RATE_MAX;
                            n_out.beat    = 1'b1;
                        end
                        OP_ZERO: begin
                            n_held        = '0;
                            n_out_valid   = 1'b1;
                            n_out.rate_bpm = '0;
                            n_out.beat    = 1'b1;
                        end
                        OP_DIV: begin
                            n_div   = i_head.divisor;
                            n_rem   = '0;
                            n_quo   = '0;
                            n_cnt   = DIV_CNT_W'(RATE_W - 1);
                            n_state = S_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem = fits ? RATE_W'(rem_sh - {1'b0, r_div}) : rem_sh[RATE_W-1:0];
                n_quo = {r_quo[RATE_W-2:0], fits};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_held         = r_quo;
                    n_out_valid    = 1'b1;
                    n_out.rate_bpm = r_quo;
                    n_out.beat     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    `PRM_ASSERT_NOW(a_div_range, i_clk, i_rst_n, r_state == S_DIV,
        (r_div != '0) && (r_div <= RATE_NUM), "divisor out of range during division")
    `PRM_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == '0),
        r_state == S_DONE, "division did not end after the last step")
    `PRM_ASSERT_NEXT(a_hold_passes_rate, i_clk, i_rst_n, o_pop && (i_head.op == OP_HOLD),
        o_out_valid && !o_out.beat && (o_out.rate_bpm == $past(r_held)),
        "plain item did not return the held rate")

endmodule

@@ hw/rtl/pulse_rate_meter.sv @@
// Top level of the pulse rate meter: front end, job queue and back end.
// Depends on prm_pkg, prm_front, prm_fifo and prm_back.
//
// Usage. Each input item carries one sensor sample and its millisecond
// timestamp on i_in; it is taken at a rising edge with i_in_valid high and
// o_in_stall low. Every item yields exactly one result item on o_out, the
// held rate in beats per minute and a beat flag, taken at an edge with
// o_out_valid high and i_out_stall low. Results leave in input order.
// The two thresholds are written on the configuration channel (index 0 is
// the upper threshold, index 1 the lower); o_cfg_ready is always high, and
// writes are meant for moments when no item is in flight.
// An item that completes no beat passes through the queue and the output
// register. An item that completes a beat with an interval of 1 to 60000 ms
// passes through the bit-serial divider in the back end, one quotient bit a
// cycle. Plain items stream at one a cycle unless the receiver stalls; a
// beat item holds the back end while it divides, and the front keeps filling
// the four-entry queue. When the receiver stalls, the result is held in the
// output register, the queue fills, and o_in_stall rises once it is full.
// Synchronous reset restores the thresholds to 512 and 100, clears the
// timing state and the held rate, and empties the queue and output register.
module pulse_rate_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  prm_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output prm_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [prm_pkg::THR_W-1:0]     i_cfg_data
);
    import prm_pkg::*;

    // Jobs flow from the front end into the queue, and the back end drains
    // them one at a time.
    logic      push;
    logic      pop;
    t_job      job;
    t_job      head;
    t_q_status q_status;

    // The front end applies the hysteresis test the moment an item is taken,
    // so the timing state is always current even while a division runs.
    prm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (job)
    );

    prm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // The back end owns the held rate, so results reflect beats in order.
    prm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for pulse_rate_meter: drives sensor items, predicts results.
// Depends on prm_pkg and the pulse_rate_meter RTL; needs no other files.
`timescale 1ns / 1ps

module tb;

    import prm_pkg::*;

    // Run limits and timing.
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [31:0] BPM_NUMERATOR = 32'd60000;
    localparam logic [RATE_W-1:0] BPM_SATURATED = 16'd60000;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Sample channel into the block.
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in = '0;

    // Result channel out of the block.
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    // Threshold write channel.
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_UPPER;
    logic [THR_W-1:0] i_cfg_data = '0;

    pulse_rate_meter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Period of 4 ns: two ns high, two ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Items waiting to be offered, and the results they are expected to give.
    t_in sample_q[$];
    t_out rate_expect_q[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Idling rates, in percent, for the sender and the receiver.
    int unsigned send_idle_pct = 11;
    int unsigned recv_idle_pct = 47;

    // Long receiver hold-off: requested by the sequence, counted down on its own.
    logic hold_start = 1'b0;
    int unsigned hold_left = 0;

    // Set when the item on the sample channel was taken at the last rising edge.
    logic in_took = 1'b0;

    // The predictor's own view of the thresholds and the detector state.
    logic [THR_W-1:0] exp_upper = 10'd512;
    logic [THR_W-1:0] exp_lower = 10'd100;
    logic [TIME_W-1:0] exp_start_ms = '0;
    logic exp_timing = 1'b0;
    logic exp_armed = 1'b0;
    logic [RATE_W-1:0] exp_rate = '0;

    // The stimulus generator's view of the thresholds and of the sensor clock.
    logic [THR_W-1:0] gen_upper = 10'd512;
    logic [THR_W-1:0] gen_lower = 10'd100;
    logic [TIME_W-1:0] gen_clock = '0;

    // Prints one line per mismatch and keeps count of them.
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Works out the result of one accepted sample and advances the predicted state.
    // The upper test comes first; the lower test then sees the timing flag as the
    // upper test has left it, which matters when the thresholds are crossed.
    function automatic t_out predict_reading(input t_in item);
        t_out res;
        logic [31:0] gap;
        res.beat = 1'b0;
        if (item.sample > exp_upper) begin
            if (exp_armed) begin
                gap = item.time_ms - exp_start_ms;
                if (gap == 32'd0) begin
                    exp_rate = BPM_SATURATED;
                end else begin
                    exp_rate = RATE_W'(BPM_NUMERATOR / gap);
                end
                exp_timing = 1'b0;
                exp_armed = 1'b0;
                res.beat = 1'b1;
            end
            if (!exp_timing) begin
                exp_start_ms = item.time_ms;
                exp_timing = 1'b1;
            end
        end
        if (item.sample < exp_lower && exp_timing) begin
            exp_armed = 1'b1;
        end
        res.rate_bpm = exp_rate;
        return res;
    endfunction

    // Everything is observed at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
            exp_upper = 10'd512;
            exp_lower = 10'd100;
            exp_start_ms = '0;
            exp_timing = 1'b0;
            exp_armed = 1'b0;
            exp_rate = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_UPPER: begin
                        exp_upper = i_cfg_data;
                    end
                    REG_LOWER: begin
                        exp_lower = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                rate_expect_q.push_back(predict_reading(i_in));
            end
            if (o_out_valid && !i_out_stall) begin
                if (rate_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result rate %0d beat %0d",
                                            o_out.rate_bpm, o_out.beat));
                end else begin
                    want = rate_expect_q.pop_front();
                    if (o_out.rate_bpm !== want.rate_bpm) begin
                        flag_mismatch($sformatf("rate_bpm %0d, expected %0d",
                                                o_out.rate_bpm, want.rate_bpm));
                    end
                    if (o_out.beat !== want.beat) begin
                        flag_mismatch($sformatf("beat %0d, expected %0d",
                                                o_out.beat, want.beat));
                    end
                end
            end
            in_took <= i_in_valid && !o_in_stall;
        end
    end

    // Sender: at the falling edge, offers the next queued item once the last one has
    // gone, or idles at random. A stalled item is held untouched.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                i_in <= sample_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, or solidly while a hold-off is running.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // The hold-off counter, in cycles, kept apart from the sequence.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_item(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] stamp);
        t_in item;
        item.sample = level;
        item.time_ms = stamp;
        sample_q.push_back(item);
    endtask

    // Sample levels relative to the thresholds the generator has written.
    function automatic logic [SAMPLE_W-1:0] above_upper();
        if (gen_upper == 10'd1023) begin
            return 10'd1023;
        end
        return SAMPLE_W'($urandom_range(1023, gen_upper + 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] below_lower();
        if (gen_lower == 10'd0) begin
            return 10'd0;
        end
        return SAMPLE_W'($urandom_range(gen_lower - 1, 0));
    endfunction

    function automatic logic [SAMPLE_W-1:0] between_thr();
        if (gen_lower <= gen_upper) begin
            return SAMPLE_W'($urandom_range(gen_upper, gen_lower));
        end
        return SAMPLE_W'($urandom_range(1023, 0));
    endfunction

    // Beat intervals: zero, tiny, heart-like, near the one-minute edge, and wild.
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(7, 0))
            0: return 32'd0;
            1: return $urandom_range(8, 1);
            2: return $urandom_range(2000, 9);
            3, 4: return $urandom_range(1500, 250);
            5: return $urandom_range(60000, 2001);
            6: return $urandom_range(60010, 59990);
            default: return $urandom();
        endcase
    endfunction

    // Fills the sample queue for one phase. Most of it is well-formed beats (a dip
    // below the lower threshold, then a peak above the upper one) with random
    // timing; the rest is noise, level-equal samples, unarmed peaks and lone dips.
    task automatic queue_phase(input int count);
        int left;
        logic [31:0] gap;
        left = count;
        push_item(above_upper(), gen_clock);
        left--;
        while (left > 0) begin
            if ($urandom_range(99, 0) < 75) begin
                gap = pick_interval();
                repeat ($urandom_range(2, 0)) begin
                    push_item(between_thr(), gen_clock + $urandom_range(gap, 0));
                    left--;
                end
                push_item(below_lower(), gen_clock + $urandom_range(gap, 0));
                left--;
                repeat ($urandom_range(1, 0)) begin
                    push_item(between_thr(), gen_clock + $urandom_range(gap, 0));
                    left--;
                end
                gen_clock = gen_clock + gap;
                push_item(above_upper(), gen_clock);
                left--;
            end else begin
                case ($urandom_range(3, 0))
                    0: push_item(SAMPLE_W'($urandom_range(1023, 0)), $urandom());
                    1: push_item(($urandom_range(1, 0) != 0) ? gen_upper : gen_lower,
                                 gen_clock + $urandom_range(3000, 0));
                    2: push_item(above_upper(), gen_clock + $urandom_range(3000, 0));
                    default: push_item(below_lower(), $urandom());
                endcase
                left--;
            end
        end
    endtask

    // Waits until every item has gone in and every result has come out, then lets
    // the back end settle before anything touches the thresholds.
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_in_valid || rate_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One phase: new thresholds while idle, new idling rates, then a batch of items.
    // With a hold-off the receiver goes quiet while the sender keeps offering, so
    // the job queue fills and the block has to stall its input.
    task automatic run_phase(input logic [THR_W-1:0] upper, input logic [THR_W-1:0] lower,
                             input int count, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit with_hold);
        wait_drained();
        write_reg(REG_UPPER, upper);
        write_reg(REG_LOWER, lower);
        gen_upper = upper;
        gen_lower = lower;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        gen_clock = ($urandom_range(3, 0) == 0) ? (32'hFFFF_FFFF - $urandom_range(5000, 0))
                                                : $urandom();
        queue_phase(count);
        if (with_hold) begin
            @(negedge i_clk);
            hold_start <= 1'b1;
            @(negedge i_clk);
            hold_start <= 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset thresholds of 512 and 100.
        push_item(10'd0, 32'd0);              // dip with no timing running: ignored
        push_item(10'd1023, 32'd1000);        // first peak starts timing
        push_item(10'd512, 32'd1001);         // equal to the upper level: neither test
        push_item(10'd100, 32'd1002);         // equal to the lower level: neither test
        push_item(10'd1023, 32'd1003);        // peak while not armed: nothing happens
        push_item(10'd99, 32'd1004);          // arms completion
        push_item(10'd513, 32'd1000);         // zero interval saturates the rate
        push_item(10'd0, 32'd1500);
        push_item(10'd1023, 32'd1001);        // one millisecond
        push_item(10'd50, 32'd0);
        push_item(10'd700, 32'd1003);         // two milliseconds
        push_item(10'd1, 32'hFFFF_FFFF);
        push_item(10'd800, 32'd61003);        // exactly one minute
        push_item(10'd0, 32'd7);
        push_item(10'd900, 32'd121004);       // just over a minute gives zero
        push_item(10'd0, 32'd0);
        push_item(10'd1023, 32'hFFFF_FFFF);   // restarts timing at the top of the clock
        push_item(10'd0, 32'hFFFF_FFFF);
        push_item(10'd1023, 32'h0000_0321);   // interval across the timestamp wrap
        push_item(10'd50, 32'h5555_5555);
        push_item(10'd600, 32'h0000_0709);    // a thousand milliseconds
        push_item(10'd341, 32'hAAAA_AAAA);
        push_item(10'd682, 32'h5555_5555);

        // Thresholds at their extremes, crossed and normal; idling swaps over after
        // the first two phases and stops for the last two.
        run_phase(10'd1023, 10'd0, 40, 11, 47, 1'b0);
        run_phase(10'd0, 10'd1023, 80, 11, 47, 1'b0);
        run_phase(10'd600, 10'd200, 200, 47, 11, 1'b0);
        run_phase(10'd300, 10'd700, 100, 47, 11, 1'b1);
        run_phase(THR_W'($urandom_range(1023, 0)), THR_W'($urandom_range(1023, 0)),
                  150, 0, 0, 1'b1);
        run_phase(10'd512, 10'd100, 180, 0, 0, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
